[rtl/core/assert_macros.svh]
// Assertion helpers shared by the echo core.
// ASSERT_PROP checks a property on every rising edge outside reset.
// ASSERT_NEVER checks that an expression is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

[rtl/core/emw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package emw_pkg;

  // sample ports on the top level
  localparam int unsigned NUM_PORTS = 8;

  localparam int unsigned DEF_MAX_DELAY_FRAMES = 16384;
  localparam int unsigned DEF_CHANNELS         = 8;
  localparam int unsigned DEF_SAMPLE_BITS      = 16;

  // register field widths
  localparam int unsigned DLY_W      = 15;
  localparam int unsigned CC_W       = 4;
  localparam int unsigned DECAY_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 2'd0,
    REG_CHANNELS = 2'd1,
    REG_DECAY    = 2'd2,
    REG_MUTED    = 2'd3
  } emw_reg_e;

  localparam logic [DLY_W-1:0]   RST_DELAY    = 15'd14400;
  localparam logic [CC_W-1:0]    RST_CHANNELS = 4'd2;
  localparam logic [DECAY_W-1:0] RST_DECAY    = 16'd16384;
  localparam logic               RST_MUTED    = 1'b0;

  // Q1.15 gain
  localparam int unsigned        GAIN_W    = 17;
  localparam int unsigned        FRAC_BITS = 15;
  localparam logic [DECAY_W-1:0] DECAY_ONE = 16'h8000;
  localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'h08000;

  // front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic                 use_store;
    logic                 frame_valid;
    logic                 tail_drained;
    logic [NUM_PORTS-1:0] lane_en;
  } emw_ctrl_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } emw_qstat_t;

endpackage

`default_nettype wire

[rtl/core/emw_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module emw_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read and write of one address return the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/emw_front.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module emw_front
  import emw_pkg::*;
#(
  parameter int unsigned MAX_DELAY_FRAMES = DEF_MAX_DELAY_FRAMES,
  parameter int unsigned CHANNELS         = DEF_CHANNELS,
  parameter int unsigned SAMPLE_BITS      = DEF_SAMPLE_BITS,
  localparam int unsigned IW = (MAX_DELAY_FRAMES > 1) ? $clog2(MAX_DELAY_FRAMES) : 1,
  localparam int unsigned LW = CHANNELS * SAMPLE_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]                  cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   req_type_i,
  input  logic [NUM_PORTS-1:0][SAMPLE_BITS-1:0]  samples_i,
  output logic [DECAY_W-1:0]                     decay_o,
  input  emw_qstat_t                             qstat_i,
  output logic                                   push_o,
  output emw_ctrl_t                              push_ctrl_o,
  output logic [LW-1:0]                          push_x_o,
  output logic                                   ram_we_o,
  output logic                                   ram_re_o,
  output logic [IW-1:0]                          ram_addr_o,
  output logic [LW-1:0]                          ram_wdata_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DELAY_FRAMES + 1);
  localparam int unsigned CMP_W = (CNT_W > DLY_W) ? CNT_W : DLY_W;
  localparam logic [CMP_W-1:0] MaxCmp = CMP_W'(MAX_DELAY_FRAMES);

  // configuration
  logic [DLY_W-1:0]   delay_q;
  logic [CC_W-1:0]    cc_q;
  logic [DECAY_W-1:0] decay_q;
  logic               muted_q;

  // ring state
  logic [IW-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] tail_q, tail_d;
  logic [CC_W-1:0]  store_cc_q, store_cc_d;

  // read-issue stage
  logic          s1_valid_q;
  emw_ctrl_t     s1_ctrl_q, ctrl_d;
  logic [LW-1:0] s1_x_q, x_d;

  logic             accept, work;
  logic             cc_bad, cc_changed, clr;
  logic [CMP_W-1:0] eff_delay, dly_ext, n_ext;
  logic [IW-1:0]    idx_use, idx_next;
  logic [CNT_W-1:0] fill_use, fill_next;
  logic             use_store;
  logic [NUM_PORTS-1:0] lane_en;
  logic [LW-1:0]    wdata_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= RST_DELAY;
      cc_q    <= RST_CHANNELS;
      decay_q <= RST_DECAY;
      muted_q <= RST_MUTED;
    end else if (cfg_we_i) begin
      unique case (emw_reg_e'(cfg_idx_i))
        REG_DELAY:    delay_q <= cfg_wdata_i[DLY_W-1:0];
        REG_CHANNELS: cc_q    <= cfg_wdata_i[CC_W-1:0];
        REG_DECAY:    decay_q <= cfg_wdata_i[DECAY_W-1:0];
        REG_MUTED:    muted_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign decay_o = decay_q;

  // room for this item and the one already in the read stage
  assign in_ready_o = (({1'b0, qstat_i.count} + (QCNT_W + 1)'(s1_valid_q))
                       < (QCNT_W + 1)'(QUEUE_DEPTH));
  assign accept = in_valid_i && in_ready_o;

  assign dly_ext   = CMP_W'(delay_q);
  assign eff_delay = (delay_q == '0) ? CMP_W'(1) :
                     ((dly_ext > MaxCmp) ? MaxCmp : dly_ext);

  assign cc_bad     = (cc_q == '0) || (cc_q > CC_W'(CHANNELS));
  assign cc_changed = (store_cc_q != cc_q);
  assign clr        = !req_type_i && cc_changed;

  // a process item after a channel count change empties the store: index, fill and tail restart
  assign idx_use  = clr ? '0 : idx_q;
  assign fill_use = clr ? '0 : fill_q;

  assign n_ext    = CMP_W'(idx_use) + CMP_W'(1);
  assign idx_next = ((n_ext >= eff_delay) || (n_ext >= MaxCmp)) ? '0 : n_ext[IW-1:0];

  // entries below the fill count hold written data, the rest read as zero
  assign use_store = (CNT_W'(idx_use) < fill_use);
  assign fill_next = (CNT_W'(idx_use) == fill_use) ? (fill_use + CNT_W'(1)) : fill_use;

  always_comb begin
    for (int l = 0; l < NUM_PORTS; l++) begin
      lane_en[l] = (l < CHANNELS) && (CC_W'(l) < cc_q);
    end
  end

  always_comb begin
    work       = 1'b0;
    ctrl_d     = '0;
    x_d        = '0;
    wdata_d    = '0;
    idx_d      = idx_q;
    fill_d     = fill_q;
    tail_d     = tail_q;
    store_cc_d = store_cc_q;
    if (cc_bad || muted_q) begin
      ctrl_d.frame_valid  = !req_type_i;
      ctrl_d.tail_drained = 1'b1;
    end else if (req_type_i) begin
      if (cc_changed || (tail_q == '0)) begin
        ctrl_d.tail_drained = 1'b1;
      end else begin
        work                = 1'b1;
        ctrl_d.use_store    = use_store;
        ctrl_d.frame_valid  = 1'b1;
        ctrl_d.tail_drained = (tail_q == CNT_W'(1));
        ctrl_d.lane_en      = lane_en;
        idx_d               = idx_next;
        fill_d              = fill_next;
        tail_d              = tail_q - CNT_W'(1);
      end
    end else begin
      work                = 1'b1;
      ctrl_d.use_store    = use_store;
      ctrl_d.frame_valid  = 1'b1;
      ctrl_d.tail_drained = 1'b0;
      ctrl_d.lane_en      = lane_en;
      for (int l = 0; l < CHANNELS; l++) begin
        x_d[l*SAMPLE_BITS +: SAMPLE_BITS]     = lane_en[l] ? samples_i[l] : '0;
        wdata_d[l*SAMPLE_BITS +: SAMPLE_BITS] = samples_i[l];
      end
      idx_d      = idx_next;
      fill_d     = fill_next;
      tail_d     = eff_delay[CNT_W-1:0];
      store_cc_d = cc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      fill_q     <= '0;
      tail_q     <= '0;
      store_cc_q <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        idx_q      <= idx_d;
        fill_q     <= fill_d;
        tail_q     <= tail_d;
        store_cc_q <= store_cc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctrl_q <= ctrl_d;
      s1_x_q    <= x_d;
    end
  end

  assign ram_we_o    = accept && work;
  assign ram_re_o    = accept && work;
  assign ram_addr_o  = idx_use;
  assign ram_wdata_o = wdata_d;

  assign push_o      = s1_valid_q;
  assign push_ctrl_o = s1_ctrl_q;
  assign push_x_o    = s1_x_q;

  `ASSERT_PROP(a_idx_within_fill, clk_i, rst_ni, CNT_W'(idx_q) <= fill_q, "index ahead of fill")
  `ASSERT_PROP(a_push_has_room, clk_i, rst_ni, s1_valid_q |-> !qstat_i.full, "queue overrun")
  `ASSERT_PROP(a_accept_pushes, clk_i, rst_ni, accept |=> s1_valid_q, "accepted item lost")
  `ASSERT_NEVER(a_tail_bound, clk_i, rst_ni, tail_q > CNT_W'(MAX_DELAY_FRAMES), "tail overflow")

endmodule

`default_nettype wire

[rtl/core/emw_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module emw_fifo
  import emw_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output emw_qstat_t       stat_o
);

  localparam logic [QPTR_W-1:0] LastPtr = QPTR_W'(QUEUE_DEPTH - 1);

  logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.count = count_q;

endmodule

`default_nettype wire

[rtl/core/emw_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module emw_back
  import emw_pkg::*;
#(
  parameter int unsigned CHANNELS    = DEF_CHANNELS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int unsigned LW = CHANNELS * SAMPLE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [DECAY_W-1:0]                    decay_i,
  input  emw_qstat_t                            qstat_i,
  input  emw_ctrl_t                             ctrl_i,
  input  logic [LW-1:0]                         x_i,
  input  logic [LW-1:0]                         d_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [NUM_PORTS-1:0][SAMPLE_BITS-1:0] out_o,
  output logic                                  frame_valid_o,
  output logic                                  tail_drained_o
);

  localparam int unsigned PW = SAMPLE_BITS + GAIN_W + 1;
  localparam int unsigned SW = SAMPLE_BITS + 1;
  localparam logic signed [SAMPLE_BITS-1:0] SatMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SatMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [GAIN_W-1:0] gain;
  logic              o_ready, m_adv;

  logic                          m_valid_q, m_fv_q, m_td_q;
  logic signed [PW-1:0]          m_prod_q [CHANNELS];
  logic signed [PW-1:0]          m_prod_d [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] m_x_q    [CHANNELS];

  logic                          out_valid_q, out_fv_q, out_td_q;
  logic signed [SAMPLE_BITS-1:0] out_q    [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] out_d    [CHANNELS];

  assign gain = (decay_i > DECAY_ONE) ? GAIN_ONE : GAIN_W'(decay_i);

  assign o_ready = !out_valid_q || out_ready_i;
  assign m_adv   = !m_valid_q || o_ready;
  assign pop_o   = !qstat_i.empty && m_adv;

  // multiply stage: delayed sample times gain, lane by lane
  always_comb begin
    logic signed [SAMPLE_BITS-1:0] d_l;
    for (int l = 0; l < CHANNELS; l++) begin
      d_l = (ctrl_i.use_store && ctrl_i.lane_en[l]) ?
            $signed(d_i[l*SAMPLE_BITS +: SAMPLE_BITS]) : '0;
      m_prod_d[l] = PW'(d_l) * PW'($signed({1'b0, gain}));
    end
  end

  // floor shift, add input, saturate
  always_comb begin
    logic signed [PW-1:0]          sh;
    logic signed [SAMPLE_BITS-1:0] sc;
    logic signed [SW-1:0]          sum;
    for (int l = 0; l < CHANNELS; l++) begin
      sh  = m_prod_q[l] >>> FRAC_BITS;
      sc  = $signed(sh[SAMPLE_BITS-1:0]);
      sum = SW'(m_x_q[l]) + SW'(sc);
      if (sum[SW-1] != sum[SW-2]) begin
        out_d[l] = sum[SW-1] ? SatMin : SatMax;
      end else begin
        out_d[l] = $signed(sum[SAMPLE_BITS-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_adv) begin
        m_valid_q <= pop_o;
      end
      if (o_ready) begin
        out_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      m_fv_q <= ctrl_i.frame_valid;
      m_td_q <= ctrl_i.tail_drained;
      for (int l = 0; l < CHANNELS; l++) begin
        m_prod_q[l] <= m_prod_d[l];
        m_x_q[l]    <= $signed(x_i[l*SAMPLE_BITS +: SAMPLE_BITS]);
      end
    end
    if (o_ready && m_valid_q) begin
      out_fv_q <= m_fv_q;
      out_td_q <= m_td_q;
      for (int l = 0; l < CHANNELS; l++) begin
        out_q[l] <= out_d[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_PORTS; l++) begin
      out_o[l] = '0;
    end
    for (int l = 0; l < CHANNELS; l++) begin
      out_o[l] = out_q[l];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_valid_o  = out_fv_q;
  assign tail_drained_o = out_td_q;

endmodule

`default_nettype wire

[rtl/core/multichannel_echo_with_tail_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Multichannel feedforward echo with a draining tail. Each item is one audio
// frame of up to eight signed samples; a process item returns input plus the
// sample stored delay_frames frames earlier times decay_q15 (Q1.15, floor),
// saturated, and a drain item returns the scaled stored frame while the tail
// lasts. Rate: one item per clock sustained while the output is taken and the
// queue has room, set by the frame-wide delay memory, which does one read and
// one write of a whole frame per item. An item passes the memory read, the
// four-entry queue between the front and the back, the gain multiply, and add
// and saturate from input accept to output valid. The delay memory needs no
// clearing pass: a fill count marks which entries were written since reset or
// the last channel-count change, and unwritten entries read as zero, so the
// block is ready from the first cycle after reset. Configuration is written
// only while the block is idle, by the user; the block does not enforce it.
module multichannel_echo_with_tail_core
  import emw_pkg::*;
#(
  parameter int unsigned MAX_DELAY_FRAMES = DEF_MAX_DELAY_FRAMES,
  parameter int unsigned CHANNELS         = DEF_CHANNELS,
  parameter int unsigned SAMPLE_BITS      = DEF_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // input items
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   req_type_i,
  input  logic [SAMPLE_BITS-1:0] sample_0_i,
  input  logic [SAMPLE_BITS-1:0] sample_1_i,
  input  logic [SAMPLE_BITS-1:0] sample_2_i,
  input  logic [SAMPLE_BITS-1:0] sample_3_i,
  input  logic [SAMPLE_BITS-1:0] sample_4_i,
  input  logic [SAMPLE_BITS-1:0] sample_5_i,
  input  logic [SAMPLE_BITS-1:0] sample_6_i,
  input  logic [SAMPLE_BITS-1:0] sample_7_i,
  // result items
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] out_0_o,
  output logic [SAMPLE_BITS-1:0] out_1_o,
  output logic [SAMPLE_BITS-1:0] out_2_o,
  output logic [SAMPLE_BITS-1:0] out_3_o,
  output logic [SAMPLE_BITS-1:0] out_4_o,
  output logic [SAMPLE_BITS-1:0] out_5_o,
  output logic [SAMPLE_BITS-1:0] out_6_o,
  output logic [SAMPLE_BITS-1:0] out_7_o,
  output logic                   frame_valid_o,
  output logic                   tail_drained_o
);

  localparam int unsigned IW = (MAX_DELAY_FRAMES > 1) ? $clog2(MAX_DELAY_FRAMES) : 1;
  localparam int unsigned LW = CHANNELS * SAMPLE_BITS;
  localparam int unsigned QW = $bits(emw_ctrl_t) + 2 * LW;

  logic [NUM_PORTS-1:0][SAMPLE_BITS-1:0] samples;
  logic [NUM_PORTS-1:0][SAMPLE_BITS-1:0] outs;

  logic [DECAY_W-1:0] decay;
  emw_qstat_t         qstat;

  // front -> queue
  logic          push;
  emw_ctrl_t     push_ctrl;
  logic [LW-1:0] push_x;

  // delay memory, one frame per word
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_addr;
  logic [LW-1:0] ram_wdata, ram_rdata;

  // queue -> back
  logic          pop;
  logic [QW-1:0] q_rdata;
  emw_ctrl_t     pop_ctrl;
  logic [LW-1:0] pop_x, pop_d;

  assign samples = {sample_7_i, sample_6_i, sample_5_i, sample_4_i,
                    sample_3_i, sample_2_i, sample_1_i, sample_0_i};

  emw_front #(
    .MAX_DELAY_FRAMES (MAX_DELAY_FRAMES),
    .CHANNELS         (CHANNELS),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .samples_i   (samples),
    .decay_o     (decay),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_ctrl_o (push_ctrl),
    .push_x_o    (push_x),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata)
  );

  // read-first memory: the read and the write of one item share an address
  emw_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_DELAY_FRAMES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // stored word is the classified item plus the delayed frame just read
  emw_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_ctrl, push_x, ram_rdata}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .stat_o  (qstat)
  );

  assign {pop_ctrl, pop_x, pop_d} = q_rdata;

  emw_back #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .decay_i        (decay),
    .qstat_i        (qstat),
    .ctrl_i         (pop_ctrl),
    .x_i            (pop_x),
    .d_i            (pop_d),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_o          (outs),
    .frame_valid_o  (frame_valid_o),
    .tail_drained_o (tail_drained_o)
  );

  assign out_0_o = outs[0];
  assign out_1_o = outs[1];
  assign out_2_o = outs[2];
  assign out_3_o = outs[3];
  assign out_4_o = outs[4];
  assign out_5_o = outs[5];
  assign out_6_o = outs[6];
  assign out_7_o = outs[7];

endmodule

`default_nettype wire
